// File: src/wavp_pkg.sv
// shared types and constants of the wav header parser and pcm unpacker
// no dependencies; compiled first
package wavp_pkg;

  // header layout
  localparam int HEADER_BYTES = 44;
  localparam int POS_W        = 6;

  localparam logic [POS_W-1:0] POS_HDR_END   = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_RIFF_END  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_WAVE_END  = POS_W'(11);
  localparam logic [POS_W-1:0] POS_FMT_END   = POS_W'(15);
  localparam logic [POS_W-1:0] POS_AFMT_END  = POS_W'(21);
  localparam logic [POS_W-1:0] POS_CHAN_END  = POS_W'(23);
  localparam logic [POS_W-1:0] POS_RATE_END  = POS_W'(27);
  localparam logic [POS_W-1:0] POS_BITS_END  = POS_W'(35);
  localparam logic [POS_W-1:0] POS_DATA_END  = POS_W'(39);

  // tags as little-endian words
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] PCM_FORMAT  = 16'd1;
  localparam logic [15:0] MONO_CHANS  = 16'd1;
  localparam logic [15:0] BITS_EIGHT  = 16'd8;

  // result kinds
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_ACCEPT = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // reject reasons
  typedef enum logic [2:0] {
    ERR_RIFF     = 3'd0,
    ERR_WAVE     = 3'd1,
    ERR_FMT      = 3'd2,
    ERR_FORMAT   = 3'd3,
    ERR_CHANNELS = 3'd4,
    ERR_DATA     = 3'd5
  } err_t;

  localparam logic [2:0] ERR_NONE = 3'd0;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] sample_value;
    logic [31:0]        sample_rate;
    logic [15:0]        sample_bits;
    logic [2:0]         error_code;
  } result_t;

endpackage

// File: src/wavp_if.sv
// valid/ready channel interfaces for file bytes and results
// no dependencies
interface wavp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       file_start;

  modport source (output valid, output file_byte, output file_start, input ready);
  modport sink   (input valid, input file_byte, input file_start, output ready);
endinterface

interface wavp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] sample_value;
  logic [31:0]        sample_rate;
  logic [15:0]        sample_bits;
  logic [2:0]         error_code;

  modport source (output valid, output kind, output sample_value, output sample_rate,
                  output sample_bits, output error_code, input ready);
  modport sink   (input valid, input kind, input sample_value, input sample_rate,
                  input sample_bits, input error_code, output ready);
endinterface

// File: src/wavp_in_reg.sv
// input register: captures one file byte beat and holds it until consumed
// depends on wavp_pkg and wavp_in_if
module wavp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  wavp_in_if.sink           in_bus,
  input  logic              consume,
  output logic              item_valid,
  output wavp_pkg::in_item_t item
);
  import wavp_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // take a new beat when empty or when the held one leaves this cycle
  assign in_bus.ready = !valid_r || consume;

  always_comb begin
    valid_nxt = valid_r;
    if (in_bus.ready) begin
      valid_nxt = in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      item_r.file_byte  <= in_bus.file_byte;
      item_r.file_start <= in_bus.file_start;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

// File: src/wavp_core.sv
// header parse state and sample unpacking for one byte per cycle while fire is high
// depends on wavp_pkg
module wavp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  wavp_pkg::in_item_t item,
  input  logic               fire,
  output logic               res_valid,
  output wavp_pkg::result_t  res
);
  import wavp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_e, pos_nxt;
  logic [31:0]      shift_r, shift_e, shift_nxt, shifted;
  logic [31:0]      rate_r, rate_e, rate_nxt;
  logic [15:0]      bits_r, bits_e, bits_nxt;
  logic [7:0]       low_r, low_nxt;
  logic             phase_r, phase_e, phase_nxt;
  logic             rej_r, rej_e, rej_nxt;
  logic             reject;
  logic [2:0]       err;
  logic [1:0]       kind;
  logic [15:0]      sample;
  logic [7:0]       b;

  assign b = item.file_byte;

  // a file start clears the parse state before this byte is used
  always_comb begin
    pos_e   = item.file_start ? '0 : pos_r;
    shift_e = item.file_start ? '0 : shift_r;
    rate_e  = item.file_start ? '0 : rate_r;
    bits_e  = item.file_start ? '0 : bits_r;
    phase_e = item.file_start ? 1'b0 : phase_r;
    rej_e   = item.file_start ? 1'b0 : rej_r;
  end

  assign shifted = {b, shift_e[31:8]};

  // parse or unpack
  always_comb begin
    pos_nxt   = pos_e;
    shift_nxt = shift_e;
    rate_nxt  = rate_e;
    bits_nxt  = bits_e;
    low_nxt   = low_r;
    phase_nxt = phase_e;
    rej_nxt   = rej_e;
    reject    = 1'b0;
    err       = ERR_NONE;
    kind      = KIND_SAMPLE;
    sample    = '0;
    res_valid = 1'b0;
    if (!rej_e) begin
      if (pos_e >= POS_HDR_END) begin
        if (bits_e == BITS_EIGHT) begin
          // (byte - 128) * 64
          res_valid = 1'b1;
          sample    = {{3{~b[7]}}, b[6:0], 6'b0};
        end else if (!phase_e) begin
          low_nxt   = b;
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          res_valid = 1'b1;
          sample    = {b, low_r};
        end
      end else begin
        shift_nxt = shifted;
        pos_nxt   = pos_e + POS_W'(1);
        case (pos_e)
          POS_RIFF_END: begin
            if (shifted != TAG_RIFF) begin
              reject = 1'b1;
              err    = ERR_RIFF;
            end
          end
          POS_WAVE_END: begin
            if (shifted != TAG_WAVE) begin
              reject = 1'b1;
              err    = ERR_WAVE;
            end
          end
          POS_FMT_END: begin
            if (shifted != TAG_FMT) begin
              reject = 1'b1;
              err    = ERR_FMT;
            end
          end
          POS_AFMT_END: begin
            if (shifted[31:16] != PCM_FORMAT) begin
              reject = 1'b1;
              err    = ERR_FORMAT;
            end
          end
          POS_CHAN_END: begin
            if (shifted[31:16] != MONO_CHANS) begin
              reject = 1'b1;
              err    = ERR_CHANNELS;
            end
          end
          POS_RATE_END: begin
            rate_nxt = shifted;
          end
          POS_BITS_END: begin
            bits_nxt = shifted[31:16];
          end
          POS_DATA_END: begin
            if (shifted != TAG_DATA) begin
              reject = 1'b1;
              err    = ERR_DATA;
            end
          end
          default: begin
          end
        endcase
        if (reject) begin
          rej_nxt   = 1'b1;
          res_valid = 1'b1;
          kind      = KIND_REJECT;
        end else if (pos_e == POS_LAST) begin
          res_valid = 1'b1;
          kind      = KIND_ACCEPT;
        end
      end
    end
  end

  // result word
  always_comb begin
    res.kind         = kind;
    res.sample_value = sample;
    res.sample_rate  = rate_nxt;
    res.sample_bits  = bits_nxt;
    res.error_code   = err;
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      shift_r <= '0;
      rate_r  <= '0;
      bits_r  <= '0;
      phase_r <= 1'b0;
      rej_r   <= 1'b0;
    end else if (fire) begin
      pos_r   <= pos_nxt;
      shift_r <= shift_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      phase_r <= phase_nxt;
      rej_r   <= rej_nxt;
    end
  end

  // pending low byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= '0;
    end else if (fire) begin
      low_r <= low_nxt;
    end
  end
endmodule

// File: src/wavp_out_reg.sv
// result register: holds one result beat until the sink takes it
// depends on wavp_pkg and wavp_out_if
module wavp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  wavp_out_if.source        out_bus,
  input  logic              load,
  input  wavp_pkg::result_t res,
  output logic              free
);
  import wavp_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  // slot is free when empty or when its beat leaves this cycle
  assign free = !valid_r || out_bus.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (free) begin
      valid_nxt = load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

  assign out_bus.valid        = valid_r;
  assign out_bus.kind         = res_r.kind;
  assign out_bus.sample_value = res_r.sample_value;
  assign out_bus.sample_rate  = res_r.sample_rate;
  assign out_bus.sample_bits  = res_r.sample_bits;
  assign out_bus.error_code   = res_r.error_code;
endmodule

// File: src/wav_header_parse_and_pcm_unpack.sv
// top level: wav header parser and mono pcm unpacker
// throughput: one byte per cycle, set by the single parse stage between the two registers
// a stalled result register holds the parse stage, which then holds the input register
// reset: synchronous active-low rst_n clears both valid flags and all parse state
// depends on wavp_pkg, wavp_if, wavp_in_reg, wavp_core and wavp_out_reg
module wav_header_parse_and_pcm_unpack (
  input  logic        clk,
  input  logic        rst_n,
  wavp_in_if.sink     in_bus,
  wavp_out_if.source  out_bus
);
  import wavp_pkg::*;

  logic     item_valid;
  in_item_t item;
  logic     fire;
  logic     free;
  logic     res_valid;
  result_t  res;

  // byte moves through the parse stage when the result slot can take it
  assign fire = item_valid && free;

  wavp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .consume    (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  wavp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res)
  );

  wavp_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .out_bus (out_bus),
    .load    (fire && res_valid),
    .res     (res),
    .free    (free)
  );
endmodule

// File: src/wavp_checker.sv
// port-level checks for the wav header parser, bound to the top level
// depends on wavp_pkg
module wavp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_sample_value,
  input logic [15:0] out_sample_bits,
  input logic [2:0]  out_error_code
);
  import wavp_pkg::*;

  // no result beat straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // a stalled result beat stays offered
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // only a reject carries an error code; accepts carry no sample
  a_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_SAMPLE || out_kind == KIND_ACCEPT)
      |-> out_error_code == ERR_NONE)
    else $error("error code on a non-reject result");

  a_accept_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ACCEPT |-> out_sample_value == 16'd0)
    else $error("sample value on an accept result");

  // eight-bit samples are scaled by 64
  a_eight_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SAMPLE && out_sample_bits == BITS_EIGHT
      |-> out_sample_value[5:0] == 6'd0)
    else $error("eight-bit sample not scaled");
endmodule

bind wav_header_parse_and_pcm_unpack wavp_checker u_wavp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_kind         (out_bus.kind),
  .out_sample_value (out_bus.sample_value),
  .out_sample_bits  (out_bus.sample_bits),
  .out_error_code   (out_bus.error_code)
);
